>>> rtl/assert_macros.svh
// Assertion macros shared by the view angle unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PVANG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvang: assertion failed");

// antecedent implies consequent after the delay dly
`define PVANG_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("pvang: delayed assertion failed");

`endif

>>> rtl/pvang_pkg.sv
// Types and constants of the pixel offset to view angle unit
package pvang_pkg;

    localparam int FW        = 16;   // focal length and pixel width
    localparam int PRE_SHIFT = 16;
    localparam int DW        = 35;   // CORDIC x/y width
    localparam int ZW        = 24;   // angle accumulator width, degrees * 65536
    localparam int AW        = 16;   // output angle width, degrees * 256
    localparam int RND_SHIFT = 8;
    localparam int TAB_LEN   = 24;

    localparam logic signed [AW-1:0] ANG_LIMIT = 16'sd23040;
    localparam logic signed [ZW-1:0] ROUND_ADD = 24'sd128;

    // atan(2^-i) in degrees * 65536
    localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
        24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945,
        24'sd234379,  24'sd117304,  24'sd58666,  24'sd29335,
        24'sd14668,   24'sd7334,    24'sd3667,   24'sd1833,
        24'sd917,     24'sd458,     24'sd229,    24'sd115,
        24'sd57,      24'sd29,      24'sd14,     24'sd7,
        24'sd4,       24'sd2,       24'sd1,      24'sd0
    };

    typedef enum logic [1:0] {
        SPEC_RUN,
        SPEC_ZERO,
        SPEC_POS_LIM,
        SPEC_NEG_LIM
    } t_spec;

    typedef struct packed {
        t_spec                 spec;
        logic signed [DW-1:0]  x;
        logic signed [DW-1:0]  y;
        logic signed [ZW-1:0]  z;
    } t_lane;

    typedef struct packed {
        logic  status;
        t_lane lx;
        t_lane ly;
    } t_data;

endpackage

>>> rtl/pvang_front.sv
// Entry stage: range check, centre offsets and CORDIC start vectors
module pvang_front import pvang_pkg::*; #(
    parameter int FRAME_SIZE = 96
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [FW-1:0] i_pix_x,
    input  logic [FW-1:0] i_pix_y,
    input  logic [FW-1:0] i_focal,
    output logic          o_vld,
    output t_data         o_d
);

    localparam int OW = $clog2(FRAME_SIZE) + 1;

    logic  r_vld;
    t_data r_d;
    t_data n_d;

    function automatic t_lane init_lane(logic [FW-1:0] pix, logic [FW-1:0] focal);
        t_lane             l;
        logic signed [OW-1:0] ofs;
        ofs    = $signed(OW'(FRAME_SIZE / 2)) - $signed(OW'(pix));
        l.x    = $signed(DW'({focal, {PRE_SHIFT{1'b0}}}));
        l.y    = $signed({{(DW-OW){ofs[OW-1]}}, ofs}) <<< PRE_SHIFT;
        l.z    = '0;
        if (ofs == '0) begin
            l.spec = SPEC_ZERO;
        end else if (focal == '0) begin
            l.spec = ofs[OW-1] ? SPEC_NEG_LIM : SPEC_POS_LIM;
        end else begin
            l.spec = SPEC_RUN;
        end
        return l;
    endfunction

    always_comb begin
        n_d.status = (i_pix_x >= FW'(FRAME_SIZE)) || (i_pix_y >= FW'(FRAME_SIZE));
        n_d.lx     = init_lane(i_pix_x, i_focal);
        n_d.ly     = init_lane(i_pix_y, i_focal);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

>>> rtl/pvang_stage.sv
// One CORDIC vectoring iteration for both axes, registered
module pvang_stage import pvang_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_data i_d,
    output logic  o_vld,
    output t_data o_d
);

    logic  r_vld;
    t_data r_d;
    t_data n_d;

    function automatic t_lane rotate(t_lane l);
        t_lane                r;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        r  = l;
        dx = $signed(l.y) >>> STEP;
        dy = $signed(l.x) >>> STEP;
        if (!l.y[DW-1]) begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + ATAN_TAB[STEP];
        end else begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - ATAN_TAB[STEP];
        end
        return r;
    endfunction

    always_comb begin
        n_d.status = i_d.status;
        n_d.lx     = rotate(i_d.lx);
        n_d.ly     = rotate(i_d.ly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

>>> rtl/pvang_round.sv
// Output stage: rounding to degrees * 256, clamping and special cases
module pvang_round import pvang_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  t_data                i_d,
    output logic                 o_done,
    output logic signed [AW-1:0] o_angle_x,
    output logic signed [AW-1:0] o_angle_y,
    output logic                 o_status
);

    logic                 r_done;
    logic signed [AW-1:0] r_angle_x;
    logic signed [AW-1:0] r_angle_y;
    logic                 r_status;
    logic signed [AW-1:0] n_angle_x;
    logic signed [AW-1:0] n_angle_y;

    function automatic logic signed [AW-1:0] finish(t_lane l, logic status);
        logic signed [ZW-1:0] acc;
        logic signed [ZW-1:0] lim;
        logic signed [AW-1:0] res;
        acc = ($signed(l.z) + ROUND_ADD) >>> RND_SHIFT;
        lim = ZW'(ANG_LIMIT);
        case (l.spec)
            SPEC_ZERO:    res = '0;
            SPEC_POS_LIM: res = ANG_LIMIT;
            SPEC_NEG_LIM: res = -ANG_LIMIT;
            default: begin
                if (acc > lim) begin
                    res = ANG_LIMIT;
                end else if (acc < -lim) begin
                    res = -ANG_LIMIT;
                end else begin
                    res = acc[AW-1:0];
                end
            end
        endcase
        if (status) begin
            res = '0;
        end
        return res;
    endfunction

    always_comb begin
        n_angle_x = finish(i_d.lx, i_d.status);
        n_angle_y = finish(i_d.ly, i_d.status);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle_x <= n_angle_x;
        r_angle_y <= n_angle_y;
        r_status  <= i_d.status;
    end

    assign o_done    = r_done;
    assign o_angle_x = r_angle_x;
    assign o_angle_y = r_angle_y;
    assign o_status  = r_status;

endmodule

>>> rtl/pixel_offset_to_view_angle_unit.sv
// Top level of the pixel offset to view angle unit
// Path from start to o_done: front register, CORDIC stage registers, output register.
// Throughput: one transaction per cycle; busy stays low, the CORDIC is
// fully unrolled with one iteration per register stage for each axis.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) clears all valid bits and sets focal length to 100.
`include "assert_macros.svh"

module pixel_offset_to_view_angle_unit import pvang_pkg::*; #(
    parameter int FRAME_SIZE   = 96,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FW-1:0]        i_pix_x,
    input  logic [FW-1:0]        i_pix_y,
    input  logic                 i_cfg_we,
    input  logic [FW-1:0]        i_cfg_wdata,
    output logic                 o_done,
    output logic signed [AW-1:0] o_angle_x,
    output logic signed [AW-1:0] o_angle_y,
    output logic                 o_status
);

    localparam int LATENCY = CORDIC_STEPS + 2;

    logic [FW-1:0] r_focal;
    logic          w_vld [CORDIC_STEPS+1];
    t_data         w_d   [CORDIC_STEPS+1];
    logic          w_ax_in_lim;
    logic          w_ay_in_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= FW'(100);
        end else if (i_cfg_we) begin
            r_focal <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    pvang_front #(
        .FRAME_SIZE (FRAME_SIZE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_pix_x (i_pix_x),
        .i_pix_y (i_pix_y),
        .i_focal (r_focal),
        .o_vld   (w_vld[0]),
        .o_d     (w_d[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        pvang_stage #(
            .STEP (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_d     (w_d[g]),
            .o_vld   (w_vld[g+1]),
            .o_d     (w_d[g+1])
        );
    end

    pvang_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_vld[CORDIC_STEPS]),
        .i_d       (w_d[CORDIC_STEPS]),
        .o_done    (o_done),
        .o_angle_x (o_angle_x),
        .o_angle_y (o_angle_y),
        .o_status  (o_status)
    );

    assign w_ax_in_lim = (o_angle_x <= ANG_LIMIT) && (o_angle_x >= -ANG_LIMIT);
    assign w_ay_in_lim = (o_angle_y <= ANG_LIMIT) && (o_angle_y >= -ANG_LIMIT);

    `PVANG_ASSERT_DLY(a_latency, i_clk, i_rst_n, start && !busy, LATENCY, o_done)
    `PVANG_ASSERT_IMP(a_oob_zero, i_clk, i_rst_n, o_done && o_status, (o_angle_x | o_angle_y) == '0)
    `PVANG_ASSERT_IMP(a_range, i_clk, i_rst_n, o_done, w_ax_in_lim && w_ay_in_lim)

endmodule
